// ===== design/i2a_pkg.sv =====
`timescale 1ns / 1ps

package i2a_pkg;

    // Default width of the integer to print.
    localparam int VALUE_WIDTH_DEF = 32;

    // Digit base selection as held in the configuration register.
    typedef logic [1:0] t_radix;

    localparam t_radix RADIX_BIN = 2'd0;
    localparam t_radix RADIX_OCT = 2'd1;
    localparam t_radix RADIX_DEC = 2'd2;
    localparam t_radix RADIX_HEX = 2'd3;

    // ASCII codes used on the output.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // Command from the sequencer to the character emitter.
    typedef struct packed {
        logic   start;
        logic   neg;
        t_radix radix;
    } t_emit_cmd;

    // Number of decimal digits that a width-bit magnitude can need.
    function automatic int dec_digits(input int width);
        return (width * 30103) / 100000 + 1;
    endfunction

    // Width of the digit shift register: wide enough for every base.
    function automatic int shift_width(input int width);
        int w_dec;
        int w_oct;
        int w_hex;
        int w_max;
        w_dec = 4 * dec_digits(width);
        w_oct = 3 * ((width + 2) / 3);
        w_hex = 4 * ((width + 3) / 4);
        w_max = width;
        if (w_dec > w_max) w_max = w_dec;
        if (w_oct > w_max) w_max = w_oct;
        if (w_hex > w_max) w_max = w_hex;
        return w_max;
    endfunction

    // ASCII character for one digit, lower-case hex letters.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d > 4'd9) begin
            return CH_LOWER_A + 8'(d) - 8'd10;
        end
        return CH_ZERO + 8'(d);
    endfunction

endpackage

// ===== design/i2a_in_if.sv =====
`timescale 1ns / 1ps

interface i2a_in_if #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== design/i2a_out_if.sv =====
`timescale 1ns / 1ps

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== design/i2a_dabble.sv =====
`timescale 1ns / 1ps

// Bit-serial binary to BCD converter (shift and add three).
// One magnitude bit enters per cycle, most significant first.
module i2a_dabble #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_start,
    input  logic [VALUE_WIDTH-1:0]                           i_mag,
    output logic                                             o_done,
    output logic [4*i2a_pkg::dec_digits(VALUE_WIDTH)-1:0]    o_bcd
);
    import i2a_pkg::*;

    localparam int NDEC = dec_digits(VALUE_WIDTH);
    localparam int BW   = 4 * NDEC;
    localparam int CW   = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BW-1:0]          r_bcd, n_bcd;
    logic [BW-1:0]          adj;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_run, n_run;
    logic                   r_done, n_done;

    // Each BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < NDEC; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Step sequencing: load, then one bit per cycle for the full width.
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_bin = i_mag;
            n_bcd = '0;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            n_bcd = {adj[BW-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(VALUE_WIDTH - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== design/i2a_emit.sv =====
`timescale 1ns / 1ps

// Character emitter: shifts digits out of a left-aligned register one per cycle
// while the output slot is free, skips leading zeros, drives the registered output.
module i2a_emit #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  i2a_pkg::t_emit_cmd                            i_cmd,
    input  logic [i2a_pkg::shift_width(VALUE_WIDTH)-1:0]  i_data,
    output logic                                          o_busy,
    i2a_out_if.source                                     o_out
);
    import i2a_pkg::*;

    localparam int NDEC = dec_digits(VALUE_WIDTH);
    localparam int NOCT = (VALUE_WIDTH + 2) / 3;
    localparam int NHEX = (VALUE_WIDTH + 3) / 4;
    localparam int SW   = shift_width(VALUE_WIDTH);
    localparam int CW   = $clog2(VALUE_WIDTH + 1);

    logic [SW-1:0] r_sh, n_sh;
    logic [SW-1:0] sh_next;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] ndig;
    t_radix        r_radix, n_radix;
    logic          r_busy, n_busy;
    logic          r_sign, n_sign;
    logic          r_lead, n_lead;
    logic          r_valid, n_valid;
    logic [7:0]    r_char, n_char;
    logic          r_last, n_last;
    logic [3:0]    digit;
    logic          slot_free;

    // Digit count for the requested base.
    always_comb begin
        unique case (i_cmd.radix)
            RADIX_BIN: ndig = CW'(VALUE_WIDTH);
            RADIX_OCT: ndig = CW'(NOCT);
            RADIX_DEC: ndig = CW'(NDEC);
            RADIX_HEX: ndig = CW'(NHEX);
            default:   ndig = CW'(NDEC);
        endcase
    end

    // Top digit of the shift register and the register after one digit.
    always_comb begin
        unique case (r_radix)
            RADIX_BIN: begin
                digit   = {3'b000, r_sh[SW-1]};
                sh_next = r_sh << 1;
            end
            RADIX_OCT: begin
                digit   = {1'b0, r_sh[SW-1 -: 3]};
                sh_next = r_sh << 3;
            end
            default: begin
                digit   = r_sh[SW-1 -: 4];
                sh_next = r_sh << 4;
            end
        endcase
    end

    assign slot_free = !r_valid || o_out.ready;

    // Load on a command, then one digit per cycle while the output slot is free.
    always_comb begin
        n_sh    = r_sh;
        n_left  = r_left;
        n_radix = r_radix;
        n_busy  = r_busy;
        n_sign  = r_sign;
        n_lead  = r_lead;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (o_out.ready) begin
            n_valid = 1'b0;
        end
        if (i_cmd.start) begin
            n_sh    = i_data;
            n_left  = ndig;
            n_radix = i_cmd.radix;
            n_busy  = 1'b1;
            n_sign  = i_cmd.neg;
            n_lead  = 1'b1;
        end else if (r_busy && slot_free) begin
            if (r_sign) begin
                n_sign  = 1'b0;
                n_valid = 1'b1;
                n_char  = CH_MINUS;
                n_last  = 1'b0;
            end else begin
                n_sh   = sh_next;
                n_left = r_left - 1'b1;
                if (!(r_lead && digit == 4'd0 && r_left != CW'(1))) begin
                    n_lead  = 1'b0;
                    n_valid = 1'b1;
                    n_char  = digit_char(digit);
                    n_last  = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_sign  <= 1'b0;
            r_lead  <= 1'b0;
            r_left  <= '0;
            r_radix <= RADIX_DEC;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_sign  <= n_sign;
            r_lead  <= n_lead;
            r_left  <= n_left;
            r_radix <= n_radix;
        end
        r_sh   <= n_sh;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_busy          = r_busy;
    assign o_out.valid     = r_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

endmodule

// ===== design/integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Binary, octal and hex values load straight into the emitter, which then takes
// one digit per cycle while the output slot is free (skipped leading zeros
// included); decimal values first pass through the bit-serial BCD converter,
// and a negative decimal value gets a leading minus sign. One number at a time:
// a new value is taken only when the block is back in idle.
// Reset (synchronous, active low) sets the base to decimal and empties the block.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  i2a_pkg::t_radix     i_cfg_wdata,
    i2a_in_if.sink              i_in,
    i2a_out_if.source           o_out
);
    import i2a_pkg::*;

    localparam int NDEC = dec_digits(VALUE_WIDTH);
    localparam int BW   = 4 * NDEC;
    localparam int NOCT = (VALUE_WIDTH + 2) / 3;
    localparam int NHEX = (VALUE_WIDTH + 3) / 4;
    localparam int SW   = shift_width(VALUE_WIDTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    t_radix                 r_radix;
    logic                   r_neg, n_neg;
    logic                   accept;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag;
    logic [SW-1:0]          aligned;
    logic [SW-1:0]          emit_data;
    logic                   dab_start;
    logic                   dab_done;
    logic [BW-1:0]          dab_bcd;
    logic                   emit_busy;
    t_emit_cmd              emit_cmd;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_DEC;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // Magnitude: negate only for a negative value in decimal.
    assign neg_in = (r_radix == RADIX_DEC) && i_in.value[VALUE_WIDTH-1];
    assign mag    = neg_in ? (~i_in.value + 1'b1) : i_in.value;

    // Left-align the raw pattern on whole digits of the selected base.
    always_comb begin
        unique case (r_radix)
            RADIX_BIN: aligned = SW'(mag) << (SW - VALUE_WIDTH);
            RADIX_OCT: aligned = SW'(mag) << (SW - 3 * NOCT);
            RADIX_HEX: aligned = SW'(mag) << (SW - 4 * NHEX);
            default:   aligned = SW'(mag) << (SW - BW);
        endcase
    end

    assign dab_start = accept && (r_radix == RADIX_DEC);

    i2a_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_mag   (mag),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    // Command to the emitter: straight from the input, or after BCD conversion.
    always_comb begin
        emit_cmd.start = 1'b0;
        emit_cmd.neg   = 1'b0;
        emit_cmd.radix = r_radix;
        emit_data      = aligned;
        if (r_state == S_CONV) begin
            emit_cmd.start = dab_done;
            emit_cmd.neg   = r_neg;
            emit_cmd.radix = RADIX_DEC;
            emit_data      = SW'(dab_bcd) << (SW - BW);
        end else begin
            emit_cmd.start = accept && (r_radix != RADIX_DEC);
        end
    end

    i2a_emit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (emit_cmd),
        .i_data  (emit_data),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

    // Sequencer: idle, BCD conversion, character emission.
    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_neg   = neg_in;
                    n_state = (r_radix == RADIX_DEC) ? S_CONV : S_EMIT;
                end
            end
            S_CONV: begin
                if (dab_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!emit_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg <= n_neg;
    end

endmodule
